// ----- src/m4vt_pkg.sv -----
// Shared types and constants for the 4x4 matrix vector transform core.
`default_nettype none

package m4vt_pkg;

	// Configuration register file: eight 64-bit pairs of Q-format elements
	localparam int NUM_PAIRS = 8;
	localparam int PAIR_W    = 64;
	localparam int ELEM_W    = 32;
	localparam int CFG_IDX_W = 4;
	localparam int PAIR_SEL_W = $clog2(NUM_PAIRS);

	// Vector form codes
	localparam logic [1:0] KIND_VEC4 = 2'd0;
	localparam logic [1:0] KIND_VEC3 = 2'd1;
	localparam logic [1:0] KIND_VEC2 = 2'd2;

	// Datapath widths: full products, pair sums, row sums
	localparam int PROD_W = 2 * ELEM_W;
	localparam int PAIR_SUM_W = PROD_W + 1;
	localparam int ROW_SUM_W = PROD_W + 2;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [ELEM_W-1:0] in_x;
		logic signed [ELEM_W-1:0] in_y;
		logic signed [ELEM_W-1:0] in_z;
		logic signed [ELEM_W-1:0] in_w;
	} vec_in_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] out_x;
		logic signed [ELEM_W-1:0] out_y;
		logic signed [ELEM_W-1:0] out_z;
		logic signed [ELEM_W-1:0] out_w;
		logic                     saturated;
	} vec_out_t;

endpackage

`default_nettype wire

// ----- src/m4vt_stream_if.sv -----
// Valid/ready stream channel carrying one payload type.
`default_nettype none

interface m4vt_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/matrix4_vector_transform_core.sv -----
// Top level: pipelined 4x4 matrix times vector transform with saturation.
//
// Multiplies each incoming vector by a 4x4 column-major matrix of signed fixed-point
// elements (FRAC_BITS fraction bits) held in eight 64-bit registers, two elements
// each, low index in the low word; reset loads the identity matrix. kind 1 forces
// w to one and zeroes out_w; kind 2 forces z and w to one and zeroes out_z and
// out_w; kind 3 acts as kind 0. Each row sum is exact, shifted right arithmetically
// by FRAC_BITS and clamped to 32 bits; saturated flags a clamp on any delivered
// component. Throughput is one vector per cycle while the sink does not stall, set by
// sixteen parallel 32x32 multipliers in one stage; there are five register stages
// (input register, products, pair sums, row sums, shift and clamp), and a request
// passes through them in that order before its result is valid. The result
// register holds while the sink stalls and earlier stages keep filling bubbles.
// Load the matrix only while no request is in flight.
`default_nettype none

module matrix4_vector_transform_core #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	m4vt_stream_if.sink                            vec_in,
	m4vt_stream_if.source                          vec_out,
	input  wire logic                              cfg_we,
	input  wire logic [m4vt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [m4vt_pkg::PAIR_W-1:0]       cfg_wdata
);

	localparam int EW = m4vt_pkg::ELEM_W;
	localparam int RW = m4vt_pkg::ROW_SUM_W;
	localparam logic [m4vt_pkg::PAIR_W-1:0] ONE_LO = 64'd1 << FRAC_BITS;
	localparam logic [m4vt_pkg::PAIR_W-1:0] ONE_HI = ONE_LO << 32;
	localparam logic signed [EW-1:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

	// Matrix registers
	logic [m4vt_pkg::PAIR_W-1:0] coef_q [m4vt_pkg::NUM_PAIRS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= ONE_LO;
			coef_q[1] <= '0;
			coef_q[2] <= ONE_HI;
			coef_q[3] <= '0;
			coef_q[4] <= '0;
			coef_q[5] <= ONE_LO;
			coef_q[6] <= '0;
			coef_q[7] <= ONE_HI;
		end else if (cfg_we && (cfg_index < m4vt_pkg::CFG_IDX_W'(m4vt_pkg::NUM_PAIRS))) begin
			coef_q[cfg_index[m4vt_pkg::PAIR_SEL_W-1:0]] <= cfg_wdata;
		end
	end

	// Stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5 = !v_s5 || vec_out.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign vec_in.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= vec_in.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Stage 1: capture vector, force unused components to one
	logic signed [EW-1:0] vec_s1 [4];
	logic dz_s1, dw_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			vec_s1[0] <= vec_in.data.in_x;
			vec_s1[1] <= vec_in.data.in_y;
			case (vec_in.data.kind)
				m4vt_pkg::KIND_VEC3: begin
					vec_s1[2] <= vec_in.data.in_z;
					vec_s1[3] <= ONE_FX;
					dz_s1 <= 1'b1;
					dw_s1 <= 1'b0;
				end
				m4vt_pkg::KIND_VEC2: begin
					vec_s1[2] <= ONE_FX;
					vec_s1[3] <= ONE_FX;
					dz_s1 <= 1'b0;
					dw_s1 <= 1'b0;
				end
				default: begin
					vec_s1[2] <= vec_in.data.in_z;
					vec_s1[3] <= vec_in.data.in_w;
					dz_s1 <= 1'b1;
					dw_s1 <= 1'b1;
				end
			endcase
		end
	end

	// Stage 2: sixteen full-width products, row i column j uses m[i + 4j]
	logic signed [m4vt_pkg::PROD_W-1:0] prod_s2 [4][4];
	logic dz_s2, dw_s2;

	for (genvar gi = 0; gi < 4; gi++) begin : g_row
		for (genvar gj = 0; gj < 4; gj++) begin : g_col
			localparam int EIDX = gi + 4 * gj;
			logic signed [EW-1:0] elem;
			assign elem = coef_q[EIDX / 2][EW * (EIDX % 2) +: EW];
			always_ff @(posedge clk) begin
				if (en_s2) prod_s2[gi][gj] <= elem * vec_s1[gj];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			dz_s2 <= dz_s1;
			dw_s2 <= dw_s1;
		end
	end

	// Stage 3: pairwise sums per row
	logic signed [m4vt_pkg::PAIR_SUM_W-1:0] pair_s3 [4][2];
	logic dz_s3, dw_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int i = 0; i < 4; i++) begin
				pair_s3[i][0] <= m4vt_pkg::PAIR_SUM_W'(prod_s2[i][0])
					+ m4vt_pkg::PAIR_SUM_W'(prod_s2[i][1]);
				pair_s3[i][1] <= m4vt_pkg::PAIR_SUM_W'(prod_s2[i][2])
					+ m4vt_pkg::PAIR_SUM_W'(prod_s2[i][3]);
			end
			dz_s3 <= dz_s2;
			dw_s3 <= dw_s2;
		end
	end

	// Stage 4: exact row sums
	logic signed [RW-1:0] sum_s4 [4];
	logic dz_s4, dw_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int i = 0; i < 4; i++) begin
				sum_s4[i] <= RW'(pair_s3[i][0]) + RW'(pair_s3[i][1]);
			end
			dz_s4 <= dz_s3;
			dw_s4 <= dw_s3;
		end
	end

	// Stage 5: arithmetic shift, clamp to 32 bits, mask undelivered components
	logic signed [RW-1:0] shifted [4];
	logic signed [EW-1:0] clamped [4];
	logic [3:0]           clip;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			shifted[i] = sum_s4[i] >>> FRAC_BITS;
			clip[i] = !((&shifted[i][RW-1:EW-1]) || !(|shifted[i][RW-1:EW-1]));
			if (!clip[i]) begin
				clamped[i] = shifted[i][EW-1:0];
			end else if (shifted[i][RW-1]) begin
				clamped[i] = {1'b1, {(EW-1){1'b0}}};
			end else begin
				clamped[i] = {1'b0, {(EW-1){1'b1}}};
			end
		end
	end

	m4vt_pkg::vec_out_t res_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			res_s5.out_x <= clamped[0];
			res_s5.out_y <= clamped[1];
			res_s5.out_z <= dz_s4 ? clamped[2] : '0;
			res_s5.out_w <= dw_s4 ? clamped[3] : '0;
			res_s5.saturated <= clip[0] || clip[1] || (dz_s4 && clip[2])
				|| (dw_s4 && clip[3]);
		end
	end

	assign vec_out.valid = v_s5;
	assign vec_out.data  = res_s5;

endmodule

`default_nettype wire
